// File: rtl/rcia_pkg.sv
`default_nettype none
package rcia_pkg;

  localparam int ID_W    = 11;
  localparam int CNT_W   = 16;
  localparam int MAX_IDS = 1024;
  localparam int IDX_W   = $clog2(MAX_IDS);
  localparam int COL_W   = 5;
  localparam int COLS    = 1 << COL_W;
  localparam int ROW_W   = IDX_W - COL_W;
  localparam int ROWS    = MAX_IDS / COLS;
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CORRUPT  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RETAIN  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_DEC,
    B_BWR
  } bstate_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] ident;
  } rcia_in_t;

  typedef struct packed {
    logic [ID_W-1:0] assigned_id;
    logic [1:0]      status;
  } rcia_out_t;

  // classified word as it sits in the queue
  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  ident;
    logic [IDX_W-1:0] idx;
    logic             id_nz;
    logic             in_table;
  } rcia_item_t;

  typedef struct packed {
    logic       valid;
    rcia_item_t item;
  } rcia_push_t;

endpackage
`default_nettype wire

// File: rtl/rcia_front.sv
`default_nettype none
module rcia_front (
  input  wire                  start,
  input  rcia_pkg::rcia_in_t   req,
  input  wire                  full,
  output logic                 busy,
  output rcia_pkg::rcia_push_t push
);

  always_comb begin
    busy               = full;
    push.valid         = start && !full;
    push.item.op       = rcia_pkg::op_t'(req.mode);
    push.item.ident    = req.ident;
    push.item.idx      = req.ident[rcia_pkg::IDX_W-1:0] - rcia_pkg::IDX_W'(1);
    push.item.id_nz    = (req.ident != '0);
    push.item.in_table = (req.ident <= rcia_pkg::ID_W'(rcia_pkg::MAX_IDS));
  end

endmodule
`default_nettype wire

// File: rtl/rcia_queue.sv
`default_nettype none
module rcia_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  rcia_pkg::rcia_push_t push,
  input  wire                  pop,
  output rcia_pkg::rcia_item_t head,
  output logic                 empty,
  output logic                 full
);

  rcia_pkg::rcia_item_t              mem [rcia_pkg::Q_DEPTH];
  logic [rcia_pkg::QPTR_W-1:0]       wp;
  logic [rcia_pkg::QPTR_W-1:0]       rp;
  logic [rcia_pkg::QCNT_W-1:0]       cnt;

  assign head  = mem[rp];
  assign empty = (cnt == '0);
  assign full  = (cnt == rcia_pkg::QCNT_W'(rcia_pkg::Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wp] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push.valid) begin
        wp <= wp + rcia_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rp <= rp + rcia_pkg::QPTR_W'(1);
      end
      case ({push.valid, pop})
        2'b10:   cnt <= cnt + rcia_pkg::QCNT_W'(1);
        2'b01:   cnt <= cnt - rcia_pkg::QCNT_W'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/rcia_back.sv
`default_nettype none
module rcia_back (
  input  wire                  clk,
  input  wire                  rst,
  input  rcia_pkg::rcia_item_t head,
  input  wire                  empty,
  output logic                 pop,
  output logic                 done,
  output rcia_pkg::rcia_out_t  rsp
);

  localparam int ID_W  = rcia_pkg::ID_W;
  localparam int CNT_W = rcia_pkg::CNT_W;
  localparam int IDX_W = rcia_pkg::IDX_W;
  localparam int COL_W = rcia_pkg::COL_W;
  localparam int COLS  = rcia_pkg::COLS;
  localparam int ROW_W = rcia_pkg::ROW_W;
  localparam int ROWS  = rcia_pkg::ROWS;
  localparam int HR_W  = ID_W - COL_W;

  function automatic logic [COLS-1:0] lt_mask(input logic [ROW_W-1:0] r,
                                              input logic [ID_W-1:0]  h);
    logic [HR_W-1:0] hr;
    logic [COLS-1:0] m;
    hr = h[ID_W-1:COL_W];
    if (HR_W'(r) < hr) begin
      m = '1;
    end else if (HR_W'(r) == hr) begin
      m = ~({COLS{1'b1}} << h[COL_W-1:0]);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  function automatic logic [COLS-1:0] bit_of(input logic [COL_W-1:0] c);
    return {{(COLS-1){1'b0}}, 1'b1} << c;
  endfunction

  function automatic logic [COL_W-1:0] first_col(input logic [COLS-1:0] v);
    logic [COL_W-1:0] k;
    k = '0;
    for (int i = COLS - 1; i >= 0; i--) begin
      if (v[i]) k = COL_W'(i);
    end
    return k;
  endfunction

  function automatic logic [ROW_W-1:0] first_row(input logic [ROWS-1:0] v);
    logic [ROW_W-1:0] k;
    k = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (v[i]) k = ROW_W'(i);
    end
    return k;
  endfunction

  // use counts; entries at or beyond the mark read as zero
  logic [CNT_W-1:0] cnt_mem [rcia_pkg::MAX_IDS];
  logic             cnt_we;
  logic [IDX_W-1:0] cnt_addr;
  logic [CNT_W-1:0] cnt_wdata;
  logic [CNT_W-1:0] cnt_rdata;

  // in-use bitmap, one row of slots per word
  logic [COLS-1:0]  map_mem [ROWS];
  logic             map_we;
  logic [ROW_W-1:0] map_addr;
  logic [COLS-1:0]  map_wdata;
  logic [COLS-1:0]  map_rdata;

  rcia_pkg::bstate_t    state, state_next;
  rcia_pkg::rcia_item_t item, item_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [ID_W-1:0]      hw, hw_next;
  logic [ROWS-1:0]      row_free, row_free_next;
  logic [ROW_W-1:0]     arow, arow_next;
  logic                 reuse, reuse_next;
  logic [ID_W-1:0]      res_id, res_id_next;
  logic                 fin;
  logic [1:0]           fin_status;

  logic             any_free;
  logic [CNT_W-1:0] cur_cnt;
  logic             id_ok;
  logic             room;
  logic [COL_W-1:0] col;
  logic [IDX_W-1:0] slot;
  logic [ID_W-1:0]  hw_alloc;
  logic [COLS-1:0]  map_set;

  always_comb begin
    any_free = |row_free;
    cur_cnt  = ({1'b0, item.idx} < hw) ? cnt_rdata : '0;
    id_ok    = item.id_nz && item.in_table && (cur_cnt != '0);
    room     = hw < ID_W'(rcia_pkg::MAX_IDS);
    col      = first_col(~map_rdata & lt_mask(arow, hw));
    slot     = reuse ? {arow, col} : hw[IDX_W-1:0];
    hw_alloc = reuse ? hw : hw + ID_W'(1);
    map_set  = map_rdata | bit_of(slot[COL_W-1:0]);
  end

  always_comb begin
    state_next    = state;
    item_next     = item;
    cnt_next      = cnt;
    hw_next       = hw;
    row_free_next = row_free;
    arow_next     = arow;
    reuse_next    = reuse;
    res_id_next   = res_id;
    pop           = 1'b0;
    cnt_we        = 1'b0;
    cnt_addr      = item.idx;
    cnt_wdata     = cnt - CNT_W'(1);
    map_we        = 1'b0;
    map_addr      = item.idx[IDX_W-1:COL_W];
    map_wdata     = map_rdata & ~bit_of(item.idx[COL_W-1:0]);
    fin           = 1'b0;
    fin_status    = rcia_pkg::ST_OK;

    case (state)
      rcia_pkg::B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          item_next  = head;
          cnt_addr   = head.idx;
          arow_next  = any_free ? first_row(row_free) : hw[IDX_W-1:COL_W];
          map_addr   = arow_next;
          reuse_next = any_free;
          state_next = rcia_pkg::B_EXEC;
        end
      end

      rcia_pkg::B_EXEC: begin
        res_id_next = item.ident;
        state_next  = rcia_pkg::B_IDLE;
        case (item.op)
          rcia_pkg::OP_ALLOC: begin
            if (!reuse && !room) begin
              res_id_next = '0;
              fin         = 1'b1;
              fin_status  = rcia_pkg::ST_FULL;
            end else begin
              cnt_we              = 1'b1;
              cnt_addr            = slot;
              cnt_wdata           = CNT_W'(1);
              map_we              = 1'b1;
              map_addr            = arow;
              map_wdata           = map_set;
              hw_next             = hw_alloc;
              row_free_next[arow] = |(~map_set & lt_mask(arow, hw_alloc));
              res_id_next         = ID_W'(slot) + ID_W'(1);
              if (item.id_nz && id_ok) begin
                cnt_next   = cur_cnt;
                state_next = rcia_pkg::B_DEC;
              end else begin
                fin        = 1'b1;
                fin_status = item.id_nz ? rcia_pkg::ST_CORRUPT : rcia_pkg::ST_OK;
              end
            end
          end
          rcia_pkg::OP_RETAIN: begin
            fin = 1'b1;
            if (!id_ok) begin
              fin_status = rcia_pkg::ST_CORRUPT;
            end else if (cur_cnt == rcia_pkg::CNT_MAX) begin
              fin_status = rcia_pkg::ST_OVERFLOW;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cur_cnt + CNT_W'(1);
            end
          end
          rcia_pkg::OP_RELEASE: begin
            if (!id_ok) begin
              fin        = 1'b1;
              fin_status = rcia_pkg::ST_CORRUPT;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cur_cnt - CNT_W'(1);
              // bitmap row read is under way for the clear
              if (cur_cnt == CNT_W'(1)) begin
                state_next = rcia_pkg::B_BWR;
              end else begin
                fin = 1'b1;
              end
            end
          end
          default: begin
            fin        = 1'b1;
            fin_status = rcia_pkg::ST_CORRUPT;
          end
        endcase
      end

      rcia_pkg::B_DEC: begin
        // old id released after the new slot is taken
        cnt_we = 1'b1;
        if (cnt == CNT_W'(1)) begin
          state_next = rcia_pkg::B_BWR;
        end else begin
          fin        = 1'b1;
          state_next = rcia_pkg::B_IDLE;
        end
      end

      rcia_pkg::B_BWR: begin
        map_we                                   = 1'b1;
        row_free_next[item.idx[IDX_W-1:COL_W]] = 1'b1;
        fin                                      = 1'b1;
        state_next                               = rcia_pkg::B_IDLE;
      end

      default: begin
        state_next = rcia_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_addr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_addr] <= map_wdata;
    end
    map_rdata <= map_mem[map_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rcia_pkg::B_IDLE;
      hw       <= '0;
      row_free <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      hw       <= hw_next;
      row_free <= row_free_next;
      done     <= fin;
    end
  end

  always_ff @(posedge clk) begin
    item   <= item_next;
    cnt    <= cnt_next;
    arow   <= arow_next;
    reuse  <= reuse_next;
    res_id <= res_id_next;
    if (fin) begin
      rsp.assigned_id <= res_id_next;
      rsp.status      <= fin_status;
    end
  end

`ifndef SYNTHESIS
  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    hw <= ID_W'(rcia_pkg::MAX_IDS))
    else $error("high-water mark beyond table size");

  a_hw_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hw >= $past(hw))
    else $error("high-water mark went down");

  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results closer than one per two cycles");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == rcia_pkg::ST_FULL |-> rsp.assigned_id == '0)
    else $error("full result carries an id");
`endif

endmodule
`default_nettype wire

// File: rtl/refcounted_id_allocator_unit.sv
`default_nettype none
// with the back end idle, a word taken at start is queued, popped, then executed; a release
// that frees its slot adds a bitmap row rewrite, and an allocate that releases a live old id
// adds a count decrement, then a bitmap row rewrite when that old id's count reaches zero
// the back end takes a new word only once it is done with the last, paced by the
// single-port count and bitmap memories; a 2-word queue lets start run ahead
// sync reset clears the mark and the free-row summary at once, no sweep

module refcounted_id_allocator_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  rcia_pkg::rcia_in_t  req,
  output logic                busy,
  output logic                done,
  output rcia_pkg::rcia_out_t rsp
);

  rcia_pkg::rcia_push_t push;
  rcia_pkg::rcia_item_t head;
  logic                 empty;
  logic                 full;
  logic                 pop;

  rcia_front u_front (
    .start (start),
    .req   (req),
    .full  (full),
    .busy  (busy),
    .push  (push)
  );

  rcia_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  rcia_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .done  (done),
    .rsp   (rsp)
  );

endmodule
`default_nettype wire

// File: test/id_table_checker.sv
module id_table_checker
  import rcia_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  input  wire       start,
  input  wire       busy,
  input  rcia_in_t  req,
  input  wire       done,
  input  rcia_out_t rsp,
  output int        errors,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHOW_MAX = 10;
  localparam int PEND_W   = 4;
  localparam int PEND_N   = 1 << PEND_W;

  logic [CNT_W-1:0]  use_cnt [MAX_IDS];
  int unsigned       hw_mark;
  rcia_out_t         want_buf [PEND_N];
  logic [PEND_W-1:0] wr_p   = '0;
  logic [PEND_W-1:0] rd_p   = '0;
  int                n_bad  = 0;
  int                n_open = 0;

  assign errors      = n_bad;
  assign outstanding = n_open;

  function automatic logic id_live(logic [ID_W-1:0] id);
    if (id == '0 || id > hw_mark || id > MAX_IDS) return 1'b0;
    return use_cnt[IDX_W'(id - 1'b1)] != '0;
  endfunction

  // updates the table for one word and returns the response it should give
  function automatic rcia_out_t predict_word(rcia_in_t w);
    rcia_out_t        r;
    logic             old_live;
    int               slot;
    logic [IDX_W-1:0] k;
    r.assigned_id = w.ident;
    r.status      = ST_OK;
    k             = IDX_W'(w.ident - 1'b1);
    case (op_t'(w.mode))
      OP_ALLOC: begin
        // old id is checked against the table as it was before the allocation
        old_live = id_live(w.ident);
        slot     = -1;
        for (int i = 0; i < hw_mark; i++) begin
          if (slot < 0 && use_cnt[IDX_W'(i)] == '0) slot = i;
        end
        if (slot < 0 && hw_mark < MAX_IDS) begin
          slot    = int'(hw_mark);
          hw_mark = hw_mark + 1;
        end
        if (slot < 0) begin
          r.assigned_id = '0;
          r.status      = ST_FULL;
        end else begin
          use_cnt[IDX_W'(slot)] = CNT_W'(1);
          r.assigned_id = ID_W'(slot + 1);
          if (w.ident != '0) begin
            if (old_live) use_cnt[k] = use_cnt[k] - 1'b1;
            else r.status = ST_CORRUPT;
          end
        end
      end
      OP_RETAIN: begin
        if (!id_live(w.ident)) r.status = ST_CORRUPT;
        else if (use_cnt[k] == CNT_MAX) r.status = ST_OVERFLOW;
        else use_cnt[k] = use_cnt[k] + 1'b1;
      end
      OP_RELEASE: begin
        if (!id_live(w.ident)) r.status = ST_CORRUPT;
        else use_cnt[k] = use_cnt[k] - 1'b1;
      end
      default: begin
        r.status = ST_CORRUPT;
      end
    endcase
    return r;
  endfunction

  task automatic flag_miss(string msg);
    n_bad = n_bad + 1;
    if (n_bad <= SHOW_MAX) $display("%0t checker: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    rcia_out_t want;
    if (rst) begin
      for (int i = 0; i < MAX_IDS; i++) use_cnt[IDX_W'(i)] = '0;
      hw_mark = 0;
      wr_p    = '0;
      rd_p    = '0;
      n_open  = 0;
    end else begin
      // compare before storing: a word never completes at the edge it is taken
      if (done) begin
        if (n_open == 0) begin
          flag_miss($sformatf("unexpected word: id %0d status %0d",
                              rsp.assigned_id, rsp.status));
        end else begin
          want   = want_buf[rd_p];
          rd_p   = rd_p + 1'b1;
          n_open = n_open - 1;
          if (rsp.assigned_id !== want.assigned_id || rsp.status !== want.status)
            flag_miss($sformatf("mismatch: want id %0d st %0d, got id %0d st %0d",
                                want.assigned_id, want.status,
                                rsp.assigned_id, rsp.status));
        end
      end
      if (start && !busy) begin
        if (n_open >= PEND_N) begin
          flag_miss("too many words in flight");
        end else begin
          want_buf[wr_p] = predict_word(req);
          wr_p           = wr_p + 1'b1;
          n_open         = n_open + 1;
        end
      end
    end
  end

endmodule

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcia_pkg::*;

  localparam int WATCHDOG = 2000;
  localparam int DRAIN    = 16;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  rcia_in_t  req   = '0;
  logic      busy;
  logic      done;
  rcia_out_t rsp;
  int        errors;
  int        outstanding;
  int        gap_pct = 0;
  int        id_span = 16;
  int        stall_n = 0;

  refcounted_id_allocator_unit i_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  id_table_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .errors     (errors),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: cycles with no word taken and no response
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_n <= 0;
    end else if (stall_n >= WATCHDOG) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_n <= stall_n + 1;
    end
  end

  // drives one word at a falling edge and returns at the edge that takes it
  task automatic put_word(op_t op, logic [ID_W-1:0] id);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req   <= '{mode: op, ident: id};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_table;
    @(negedge clk);
    start <= 1'b0;
    wait (outstanding == 0);
  endtask

  task automatic put_random;
    int unsigned pick;
    logic [ID_W-1:0] id;
    pick = $urandom_range(99);
    id   = ID_W'($urandom_range(id_span, 1));
    if (pick < 3) begin
      put_word(OP_NONE, ID_W'($urandom_range(2047)));
    end else if (pick < 7) begin
      // noise: any id at all
      put_word(op_t'($urandom_range(2)), ID_W'($urandom_range(2047)));
    end else if (pick < 40) begin
      put_word(OP_ALLOC, $urandom_range(1) ? id : '0);
    end else if (pick < 70) begin
      put_word(OP_RETAIN, id);
    end else begin
      put_word(OP_RELEASE, id);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    gap_pct = 10;
    put_word(OP_RETAIN, 11'd1);
    put_word(OP_ALLOC, 11'd0);
    put_word(OP_ALLOC, 11'd0);
    put_word(OP_RETAIN, 11'd1);
    put_word(OP_RELEASE, 11'd1);
    put_word(OP_RELEASE, 11'd1);
    put_word(OP_RELEASE, 11'd1);
    put_word(OP_RETAIN, 11'd0);
    put_word(OP_RELEASE, 11'd0);
    put_word(OP_RETAIN, 11'd2047);
    put_word(OP_RELEASE, 11'd1024);
    put_word(OP_NONE, 11'd2);
    put_word(OP_NONE, 11'd2047);
    put_word(OP_ALLOC, 11'd0);
    put_word(OP_ALLOC, 11'd2);
    // id 2 is free again, so the new id is 2 and the old id was dead
    put_word(OP_ALLOC, 11'd2);
    put_word(OP_ALLOC, 11'd1024);
    put_word(OP_ALLOC, 11'd2047);
    drain_table();

    put_word(OP_RETAIN, 11'd1);
    put_word(OP_RELEASE, 11'd1);

    gap_pct = 10;
    id_span = 16;
    for (int i = 0; i < 230; i++) put_random();

    gap_pct = 61;
    id_span = 40;
    for (int i = 0; i < 230; i++) put_random();
    drain_table();

    // fill the table to capacity, then work on a full table
    gap_pct = 0;
    for (int i = 0; i < 1040; i++) put_word(OP_ALLOC, '0);
    id_span = MAX_IDS;
    for (int i = 0; i < 230; i++) put_random();

    drain_table();
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
